// ----- src/bgr_to_nv12_convert_defines.svh -----
// assertion macros for the bgr to nv12 converter
// expects i_clk and i_rst_n in the scope of the module that uses them
`ifndef BGR_TO_NV12_CONVERT_DEFINES_SVH
`define BGR_TO_NV12_CONVERT_DEFINES_SVH

// same-cycle implication
`define BGR2NV_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BGR2NV_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/bgr2nv_pkg.sv -----
// shared constants, types and helpers of the bgr to nv12 converter
// no dependencies
`default_nettype none

package bgr2nv_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 2048;

    localparam int SLOT_DEPTH = MAX_WIDTH / 2;
    localparam int SLOT_W     = $clog2(SLOT_DEPTH);
    localparam int CFG_W      = 12;
    localparam int POS_W      = 11;
    localparam int CROW_W     = 10;
    localparam int PAIR_W     = 9;
    localparam int ENTRY_W    = 2 * PAIR_W;

    localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [1:0] REG_FLIP_ROWS    = 2'd2;

    localparam logic [CFG_W-1:0] RST_FRAME_WIDTH  = 12'd640;
    localparam logic [CFG_W-1:0] RST_FRAME_HEIGHT = 12'd480;

    localparam logic signed [17:0] Y_R = 18'sd66;
    localparam logic signed [17:0] Y_G = 18'sd129;
    localparam logic signed [17:0] Y_B = 18'sd25;
    localparam logic signed [17:0] U_R = -18'sd38;
    localparam logic signed [17:0] U_G = -18'sd74;
    localparam logic signed [17:0] U_B = 18'sd112;
    localparam logic signed [17:0] V_R = 18'sd112;
    localparam logic signed [17:0] V_G = -18'sd94;
    localparam logic signed [17:0] V_B = -18'sd18;
    localparam logic signed [17:0] ROUND_C = 18'sd128;
    localparam logic [7:0]         LUMA_OFS = 8'd16;
    localparam logic signed [11:0] CHROMA_OFS = 12'sd128;

    typedef struct packed {
        logic [7:0]        luma;
        logic signed [7:0] u_term;
        logic signed [7:0] v_term;
    } t_terms;

    typedef struct packed {
        logic [POS_W-1:0] col;
        logic [POS_W-1:0] orow;
        logic             row_odd;
        logic             last;
    } t_pos;

    function automatic logic [CFG_W-1:0] eff_size(input logic [CFG_W-1:0] v,
                                                  input int maxv);
        logic [CFG_W-1:0] s;
        s = v;
        if (s < 12'd2) s = 12'd2;
        if (s > CFG_W'(maxv)) s = CFG_W'(maxv);
        return {s[CFG_W-1:1], 1'b0};
    endfunction

    function automatic logic [7:0] clip8(input logic signed [11:0] v);
        logic [7:0] c;
        if (v < 12'sd0) c = 8'd0;
        else if (v > 12'sd255) c = 8'd255;
        else c = v[7:0];
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- src/bgr2nv_csc.sv -----
// bt.601 color space terms: luma sample and per-pixel u/v terms
// depends on bgr2nv_pkg
`default_nettype none

module bgr2nv_csc (
    input  wire logic [7:0]          i_blue,
    input  wire logic [7:0]          i_green,
    input  wire logic [7:0]          i_red,
    output bgr2nv_pkg::t_terms       o_terms
);
    import bgr2nv_pkg::*;

    logic signed [17:0] b_s, g_s, r_s;
    logic signed [17:0] y_acc, u_acc, v_acc;
    logic [7:0]         y_q;

    assign b_s = $signed({10'd0, i_blue});
    assign g_s = $signed({10'd0, i_green});
    assign r_s = $signed({10'd0, i_red});

    assign y_acc = Y_R * r_s + Y_G * g_s + Y_B * b_s + ROUND_C;
    assign u_acc = U_R * r_s + U_G * g_s + U_B * b_s + ROUND_C;
    assign v_acc = V_R * r_s + V_G * g_s + V_B * b_s + ROUND_C;

    // floor division by 256, results fit in eight bits
    assign y_q = y_acc[15:8];

    assign o_terms.luma   = y_q + LUMA_OFS;
    assign o_terms.u_term = u_acc[15:8];
    assign o_terms.v_term = v_acc[15:8];

endmodule

`default_nettype wire

// ----- src/bgr_to_nv12_convert.sv -----
// bgr pixel stream to nv12 luma and interleaved chroma, bt.601 integer
// input, terms and output registers; one pixel per clock while the output
// is not stalled; the line store takes one read and one write per cycle
// synchronous active-low reset: 640x480, no flip, counters cleared; the line
// store is not cleared, each entry is written in the even row before use
// depends on bgr2nv_pkg, bgr2nv_csc, bgr_to_nv12_convert_defines.svh
`default_nettype none
`include "bgr_to_nv12_convert_defines.svh"

module bgr_to_nv12_convert (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // apb configuration
    input  wire logic        i_psel,
    input  wire logic        i_penable,
    input  wire logic        i_pwrite,
    input  wire logic [3:0]  i_paddr,
    input  wire logic [31:0] i_pwdata,
    output logic [31:0]      o_prdata,
    output logic             o_pready,
    // pixel input
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [23:0] i_s_axis_tdata,  // blue, green, red
    // result output
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // luma_value, luma_row, luma_col, u_value, v_value, chroma_row,
    // chroma_byte_col, zero pad
    output logic [71:0]      o_m_axis_tdata,
    output logic             o_m_axis_tuser,  // chroma_valid
    output logic             o_m_axis_tlast   // frame_last
);
    import bgr2nv_pkg::*;

    // configuration
    logic [CFG_W-1:0] r_frame_width, r_frame_height;
    logic             r_flip_rows;
    logic [CFG_W-1:0] w_eff, h_eff;
    logic             cfg_wr, cfg_hit;
    logic [1:0]       cfg_idx;

    // counters
    logic [POS_W-1:0] r_col, r_row;
    logic [POS_W-1:0] cur_col, cur_row, n_col, n_row;
    t_pos             n_pos;

    // pipeline
    logic             r_p1_valid, r_p2_valid, r_out_valid;
    logic [23:0]      r_p1_pix;
    t_pos             r_p1_pos, r_p2_pos;
    t_terms           p1_terms, r_p2_terms;
    logic             rdy_out, rdy_p2, rdy_p1, in_fire, mv_p1, mv_p2;

    // line store
    logic [ENTRY_W-1:0] mem [SLOT_DEPTH];
    logic [ENTRY_W-1:0] r_rd_data;
    logic               rd_en, mem_we;
    logic [SLOT_W-1:0]  rd_addr, wr_addr;
    logic [ENTRY_W-1:0] wr_data;

    // chroma combine
    logic signed [7:0]  r_hold_u, r_hold_v;
    logic [PAIR_W-1:0]  pair_u, pair_v;
    logic signed [10:0] sum_u, sum_v, q_u, q_v;
    logic               chroma;

    // output registers
    logic [7:0]        r_out_luma, r_out_u, r_out_v;
    logic [POS_W-1:0]  r_out_row, r_out_col, r_out_cbc;
    logic [CROW_W-1:0] r_out_crow;
    logic              r_out_cvalid, r_out_last;

    assign cfg_wr  = i_psel && i_penable && i_pwrite && o_pready;
    assign cfg_idx = i_paddr[3:2];
    assign cfg_hit = cfg_wr && (cfg_idx == REG_FRAME_WIDTH || cfg_idx == REG_FRAME_HEIGHT
                                || cfg_idx == REG_FLIP_ROWS);
    assign o_pready = 1'b1;

    always_comb begin
        case (cfg_idx)
            REG_FRAME_WIDTH:  o_prdata = {20'd0, r_frame_width};
            REG_FRAME_HEIGHT: o_prdata = {20'd0, r_frame_height};
            REG_FLIP_ROWS:    o_prdata = {31'd0, r_flip_rows};
            default:          o_prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= RST_FRAME_WIDTH;
            r_frame_height <= RST_FRAME_HEIGHT;
            r_flip_rows    <= 1'b0;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_FRAME_WIDTH:  r_frame_width  <= i_pwdata[CFG_W-1:0];
                REG_FRAME_HEIGHT: r_frame_height <= i_pwdata[CFG_W-1:0];
                REG_FLIP_ROWS:    r_flip_rows    <= i_pwdata[0];
                default: ;
            endcase
        end
    end

    assign w_eff = eff_size(r_frame_width, MAX_WIDTH);
    assign h_eff = eff_size(r_frame_height, MAX_HEIGHT);

    // handshake chain
    assign rdy_out = !r_out_valid || i_m_axis_tready;
    assign rdy_p2  = !r_p2_valid || rdy_out;
    assign rdy_p1  = !r_p1_valid || rdy_p2;
    assign o_s_axis_tready = rdy_p1;
    assign in_fire = i_s_axis_tvalid && o_s_axis_tready;
    assign mv_p1   = r_p1_valid && rdy_p2;
    assign mv_p2   = r_p2_valid && rdy_out;

    // position of the incoming pixel
    always_comb begin
        cur_col = ({1'b0, r_col} >= w_eff) ? '0 : r_col;
        cur_row = ({1'b0, r_row} >= h_eff) ? '0 : r_row;
        n_pos.col     = cur_col;
        n_pos.orow    = r_flip_rows ? POS_W'(h_eff - 12'd1 - {1'b0, cur_row}) : cur_row;
        n_pos.row_odd = cur_row[0];
        n_pos.last    = ({1'b0, cur_col} == w_eff - 12'd1)
                        && ({1'b0, cur_row} == h_eff - 12'd1);
        if ({1'b0, cur_col} + 12'd1 >= w_eff) begin
            n_col = '0;
            n_row = ({1'b0, cur_row} + 12'd1 >= h_eff) ? '0 : cur_row + 11'd1;
        end else begin
            n_col = cur_col + 11'd1;
            n_row = cur_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (cfg_hit) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_fire) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid  <= 1'b0;
            r_p2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire) r_p1_valid <= 1'b1;
            else if (mv_p1) r_p1_valid <= 1'b0;
            if (mv_p1) r_p2_valid <= 1'b1;
            else if (mv_p2) r_p2_valid <= 1'b0;
            if (mv_p2) r_out_valid <= 1'b1;
            else if (i_m_axis_tready) r_out_valid <= 1'b0;
        end
    end

    // stage 1: input register
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_p1_pix <= i_s_axis_tdata;
            r_p1_pos <= n_pos;
        end
    end

    bgr2nv_csc u_csc (
        .i_blue  (r_p1_pix[7:0]),
        .i_green (r_p1_pix[15:8]),
        .i_red   (r_p1_pix[23:16]),
        .o_terms (p1_terms)
    );

    // stage 2: terms, line store read
    always_ff @(posedge i_clk) begin
        if (mv_p1) begin
            r_p2_terms <= p1_terms;
            r_p2_pos   <= r_p1_pos;
        end
    end

    assign rd_en   = mv_p1 && r_p1_pos.col[0] && r_p1_pos.row_odd;
    assign rd_addr = r_p1_pos.col[POS_W-1:1];

    assign pair_u  = {r_hold_u[7], r_hold_u} + {r_p2_terms.u_term[7], r_p2_terms.u_term};
    assign pair_v  = {r_hold_v[7], r_hold_v} + {r_p2_terms.v_term[7], r_p2_terms.v_term};
    assign mem_we  = mv_p2 && r_p2_pos.col[0] && !r_p2_pos.row_odd;
    assign wr_addr = r_p2_pos.col[POS_W-1:1];
    assign wr_data = {pair_v, pair_u};

    always_ff @(posedge i_clk) begin
        if (mem_we) mem[wr_addr] <= wr_data;
        if (rd_en) r_rd_data <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_u <= '0;
            r_hold_v <= '0;
        end else if (mv_p2 && !r_p2_pos.col[0]) begin
            r_hold_u <= r_p2_terms.u_term;
            r_hold_v <= r_p2_terms.v_term;
        end
    end

    // block sums, divide by four truncating toward zero
    assign chroma = r_p2_pos.col[0] && r_p2_pos.row_odd;
    assign sum_u  = {{2{r_rd_data[PAIR_W-1]}}, r_rd_data[PAIR_W-1:0]}
                    + {{2{pair_u[PAIR_W-1]}}, pair_u};
    assign sum_v  = {{2{r_rd_data[ENTRY_W-1]}}, r_rd_data[ENTRY_W-1:PAIR_W]}
                    + {{2{pair_v[PAIR_W-1]}}, pair_v};
    assign q_u    = sum_u[10] ? ((sum_u + 11'sd3) >>> 2) : (sum_u >>> 2);
    assign q_v    = sum_v[10] ? ((sum_v + 11'sd3) >>> 2) : (sum_v >>> 2);

    // stage 3: output register
    always_ff @(posedge i_clk) begin
        if (mv_p2) begin
            r_out_luma   <= r_p2_terms.luma;
            r_out_row    <= r_p2_pos.orow;
            r_out_col    <= r_p2_pos.col;
            r_out_cvalid <= chroma;
            r_out_last   <= r_p2_pos.last;
            if (chroma) begin
                r_out_u    <= clip8({q_u[10], q_u} + CHROMA_OFS);
                r_out_v    <= clip8({q_v[10], q_v} + CHROMA_OFS);
                r_out_crow <= r_p2_pos.orow[POS_W-1:1];
                r_out_cbc  <= r_p2_pos.col - 11'd1;
            end else begin
                r_out_u    <= '0;
                r_out_v    <= '0;
                r_out_crow <= '0;
                r_out_cbc  <= '0;
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {5'd0, r_out_cbc, r_out_crow, r_out_v, r_out_u,
                              r_out_col, r_out_row, r_out_luma};
    assign o_m_axis_tuser  = r_out_cvalid;
    assign o_m_axis_tlast  = r_out_last;

    `BGR2NV_ASSERT_IMP(a_store_no_clash, mem_we && rd_en, wr_addr != rd_addr, "line store read and write collide")
    `BGR2NV_ASSERT_IMP(a_col_in_range, 1'b1, {1'b0, r_col} < w_eff, "column counter out of range")
    `BGR2NV_ASSERT_IMP(a_chroma_odd_col, r_out_valid && r_out_cvalid, r_out_col[0], "chroma on even column")
    `BGR2NV_ASSERT_NXT(a_p2_holds, r_p2_valid && !rdy_out, r_p2_valid, "stage 2 lost while stalled")

endmodule

`default_nettype wire

// ----- bench/nv12_result_monitor.sv -----
// result monitor of the bgr to nv12 converter: tracks the register writes, predicts each
// pixel's luma, position and block chroma, and compares every result transfer field by field
// depends on bgr2nv_pkg
module nv12_result_monitor
    import bgr2nv_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [3:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    input  logic [31:0] o_prdata,
    input  logic        o_pready,
    input  logic        i_s_axis_tvalid,
    input  logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,
    input  logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    input  logic [71:0] o_m_axis_tdata,
    input  logic        o_m_axis_tuser,
    input  logic        o_m_axis_tlast,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_chroma_count,
    output int          o_frame_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0]  luma;
        logic [10:0] luma_row;
        logic [10:0] luma_col;
        logic        chroma_valid;
        logic [7:0]  u_value;
        logic [7:0]  v_value;
        logic [9:0]  chroma_row;
        logic [10:0] chroma_col;
        logic        frame_last;
    } t_nv12_sample;

    t_nv12_sample predicted_samples[$];
    t_nv12_sample want;

    logic [11:0] width_cfg;
    logic [11:0] height_cfg;
    logic        flip_cfg;
    int          col_pos;
    int          row_pos;
    int          hold_u;
    int          hold_v;
    logic [17:0] pair_sums [0:SLOT_DEPTH-1];
    int          read_want;
    logic        read_known;

    function automatic int even_size(input int v, input int maxv);
        int s;
        s = v;
        if (s < 2) s = 2;
        if (s > maxv) s = maxv;
        return s & ~1;
    endfunction

    function automatic logic [7:0] clip_byte(input int v);
        if (v < 0) return 8'd0;
        if (v > 255) return 8'd255;
        return v[7:0];
    endfunction

    task automatic compare_field(input string field, input int exp_val, input int act_val);
        if (exp_val != act_val) begin
            $error("%s: expected %0d, actual %0d", field, exp_val, act_val);
            o_fail_count++;
        end
    endtask

    // luma of every pixel, chroma of the 2x2 block on the odd column of an odd row
    task automatic convert_pixel(input logic [23:0] pix);
        t_nv12_sample s;
        int w, h, b, g, r, col, row, orow, ut, vt, us, vs;
        logic [17:0] entry;
        w = even_size(width_cfg, MAX_WIDTH);
        h = even_size(height_cfg, MAX_HEIGHT);
        b = pix[7:0];
        g = pix[15:8];
        r = pix[23:16];
        if (col_pos >= w) col_pos = 0;
        if (row_pos >= h) row_pos = 0;
        col  = col_pos;
        row  = row_pos;
        orow = flip_cfg ? h - 1 - row : row;
        ut = (-38 * r - 74 * g + 112 * b + 128) >>> 8;
        vt = (112 * r - 94 * g - 18 * b + 128) >>> 8;
        s = '0;
        s.luma     = clip_byte(((66 * r + 129 * g + 25 * b + 128) >>> 8) + 16);
        s.luma_row = orow[10:0];
        s.luma_col = col[10:0];
        if (col % 2 == 0) begin
            hold_u = ut;
            hold_v = vt;
        end else if (row % 2 == 0) begin
            vs = hold_v + vt;
            us = hold_u + ut;
            pair_sums[col >> 1] = {vs[8:0], us[8:0]};
        end else begin
            entry = pair_sums[col >> 1];
            us = $signed(entry[8:0]);
            vs = $signed(entry[17:9]);
            us = us + hold_u + ut;
            vs = vs + hold_v + vt;
            s.chroma_valid = 1'b1;
            s.u_value      = clip_byte(us / 4 + 128);
            s.v_value      = clip_byte(vs / 4 + 128);
            s.chroma_row   = orow[10:1];
            s.chroma_col   = 11'(col - 1);
        end
        s.frame_last = (col == w - 1) && (row == h - 1);
        if (col + 1 >= w) begin
            col_pos = 0;
            row_pos = (row + 1 >= h) ? 0 : row + 1;
        end else begin
            col_pos = col + 1;
        end
        predicted_samples.push_back(s);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            width_cfg      = RST_FRAME_WIDTH;
            height_cfg     = RST_FRAME_HEIGHT;
            flip_cfg       = 1'b0;
            col_pos        = 0;
            row_pos        = 0;
            hold_u         = 0;
            hold_v         = 0;
            o_fail_count   = 0;
            o_chroma_count = 0;
            o_frame_count  = 0;
            predicted_samples.delete();
        end else begin
            if (i_psel && i_penable && o_pready) begin
                read_known = 1'b1;
                read_want  = 0;
                case (i_paddr[3:2])
                    REG_FRAME_WIDTH: begin
                        if (i_pwrite) width_cfg = i_pwdata[11:0];
                        read_want = width_cfg;
                    end
                    REG_FRAME_HEIGHT: begin
                        if (i_pwrite) height_cfg = i_pwdata[11:0];
                        read_want = height_cfg;
                    end
                    REG_FLIP_ROWS: begin
                        if (i_pwrite) flip_cfg = i_pwdata[0];
                        read_want = flip_cfg;
                    end
                    default: begin
                        read_known = 1'b0;
                    end
                endcase
                if (!i_pwrite) begin
                    if (read_known) compare_field("prdata", read_want, o_prdata);
                end else if (read_known) begin
                    col_pos = 0;
                    row_pos = 0;
                end
            end
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (predicted_samples.size() == 0) begin
                    $error("result transfer with no pixel waiting");
                    o_fail_count++;
                end else begin
                    want = predicted_samples.pop_front();
                    compare_field("luma_value", want.luma, o_m_axis_tdata[7:0]);
                    compare_field("luma_row", want.luma_row, o_m_axis_tdata[18:8]);
                    compare_field("luma_col", want.luma_col, o_m_axis_tdata[29:19]);
                    compare_field("u_value", want.u_value, o_m_axis_tdata[37:30]);
                    compare_field("v_value", want.v_value, o_m_axis_tdata[45:38]);
                    compare_field("chroma_row", want.chroma_row, o_m_axis_tdata[55:46]);
                    compare_field("chroma_byte_col", want.chroma_col, o_m_axis_tdata[66:56]);
                    compare_field("chroma_valid", want.chroma_valid, o_m_axis_tuser);
                    compare_field("frame_last", want.frame_last, o_m_axis_tlast);
                    if (want.chroma_valid) o_chroma_count++;
                    if (want.frame_last) o_frame_count++;
                end
            end
            if (i_s_axis_tvalid && o_s_axis_tready) convert_pixel(i_s_axis_tdata);
        end
        o_pending = predicted_samples.size();
    end

endmodule

// ----- bench/bgr_to_nv12_convert_test.sv -----
// top of the bgr to nv12 converter bench: clock, reset, register setup, pixel stimulus with
// random gaps and output stalls, watchdog and verdict
// depends on bgr2nv_pkg, bgr_to_nv12_convert and nv12_result_monitor
module bgr_to_nv12_convert_test;
    import bgr2nv_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] REG_UNUSED     = 2'd3;
    localparam int         PIXEL_TARGET   = 1900;
    localparam int         WATCHDOG_LIMIT = 2000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_psel = 1'b0;
    logic        i_penable = 1'b0;
    logic        i_pwrite = 1'b0;
    logic [3:0]  i_paddr = '0;
    logic [31:0] i_pwdata = '0;
    logic [31:0] o_prdata;
    logic        o_pready;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [23:0] i_s_axis_tdata = '0;  // blue, green, red
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    // luma_value, luma_row, luma_col, u_value, v_value, chroma_row, chroma_byte_col, zero pad
    logic [71:0] o_m_axis_tdata;
    logic        o_m_axis_tuser;  // chroma_valid
    logic        o_m_axis_tlast;  // frame_last

    int   fail_count;
    int   pending;
    int   chroma_count;
    int   frame_count;
    int   pixels_sent = 0;
    int   settings_written = 0;
    int   idle_cycles = 0;
    int   stall_left = 0;
    int   drain_gap;
    logic steady = 1'b0;

    bgr_to_nv12_convert uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_psel          (i_psel),
        .i_penable       (i_penable),
        .i_pwrite        (i_pwrite),
        .i_paddr         (i_paddr),
        .i_pwdata        (i_pwdata),
        .o_prdata        (o_prdata),
        .o_pready        (o_pready),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    nv12_result_monitor monitor (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_psel          (i_psel),
        .i_penable       (i_penable),
        .i_pwrite        (i_pwrite),
        .i_paddr         (i_paddr),
        .i_pwdata        (i_pwdata),
        .o_prdata        (o_prdata),
        .o_pready        (o_pready),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_chroma_count  (chroma_count),
        .o_frame_count   (frame_count)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [23:0] random_pixel();
        logic [23:0] pix;
        pix = $urandom;
        // saturated channels now and then
        if ($urandom_range(0, 7) == 0) begin
            pix[7:0]   = {8{pix[0]}};
            pix[15:8]  = {8{pix[8]}};
            pix[23:16] = {8{pix[16]}};
        end
        return pix;
    endfunction

    // called and returns at a falling edge; leaves tvalid high for the caller to lower or reuse
    task automatic push_pixel(input logic [23:0] pix);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= pix;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
        pixels_sent++;
    endtask

    task automatic wait_idle();
        i_s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic apb_access(input logic write, input logic [1:0] index,
                              input logic [31:0] data);
        i_psel    <= 1'b1;
        i_penable <= 1'b0;
        i_pwrite  <= write;
        i_paddr   <= {index, 2'b00};
        i_pwdata  <= data;
        @(negedge i_clk);
        i_penable <= 1'b1;
        @(posedge i_clk);
        while (!o_pready) @(posedge i_clk);
        @(negedge i_clk);
        i_psel    <= 1'b0;
        i_penable <= 1'b0;
        @(negedge i_clk);
    endtask

    // writes the selected registers with random upper bits, then reads back all three
    task automatic set_frame(input logic [11:0] w, input logic [11:0] h, input logic flip,
                             input logic [2:0] sel);
        logic [31:0] data;
        if (sel[0]) begin
            data = $urandom;
            data[11:0] = w;
            apb_access(1'b1, REG_FRAME_WIDTH, data);
        end
        if (sel[1]) begin
            data = $urandom;
            data[11:0] = h;
            apb_access(1'b1, REG_FRAME_HEIGHT, data);
        end
        if (sel[2]) begin
            data = $urandom;
            data[0] = flip;
            apb_access(1'b1, REG_FLIP_ROWS, data);
        end
        apb_access(1'b0, REG_FRAME_WIDTH, '0);
        apb_access(1'b0, REG_FRAME_HEIGHT, '0);
        apb_access(1'b0, REG_FLIP_ROWS, '0);
        settings_written++;
    endtask

    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            drain_gap = pick_gap();
            i_m_axis_tready <= (drain_gap == 0);
            if (drain_gap > 0) stall_left <= drain_gap - 1;
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready) ||
            (i_psel && i_penable && o_pready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        int count;
        logic [11:0] w;
        logic [11:0] h;
        logic [2:0] sel;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset geometry 640x480
        push_pixel(24'h000000);
        push_pixel(24'hFFFFFF);
        push_pixel(24'h0000FF);
        push_pixel(24'hFF0000);
        wait_idle();

        // sizes below two, flipped 2x2 frames; unused register index mid frame
        set_frame(12'd1, 12'd0, 1'b1, 3'b111);
        push_pixel(24'h0000FF);
        push_pixel(24'h0000FF);
        push_pixel(24'h0000FF);
        push_pixel(24'h0000FF);
        push_pixel(24'hFF0000);
        push_pixel(24'hFF0000);
        wait_idle();
        apb_access(1'b1, REG_UNUSED, $urandom);
        push_pixel(24'hFF0000);
        push_pixel(24'hFF0000);
        wait_idle();

        // odd sizes round down to 4x2
        set_frame(12'd5, 12'd3, 1'b0, 3'b111);
        push_pixel(24'hFFFF00);
        push_pixel(24'hFFFF00);
        push_pixel(24'h00FFFF);
        push_pixel(24'h00FFFF);
        push_pixel(24'hFFFF00);
        push_pixel(24'hFFFF00);
        push_pixel(24'h00FFFF);
        push_pixel(24'h00FFFF);
        wait_idle();

        // oversize saturates to the maximum frame, flipped so the first row lands on row 2047
        set_frame(12'hFFF, 12'hFFF, 1'b1, 3'b111);
        push_pixel(24'h00FF00);
        push_pixel(24'h808080);
        push_pixel(24'h123456);
        push_pixel(24'hFEDCBA);
        wait_idle();

        while (pixels_sent < PIXEL_TARGET) begin
            steady = ($urandom_range(0, 3) == 0);
            sel = $urandom_range(1, 7);
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: begin
                    w = $urandom_range(0, 12);
                    h = $urandom_range(0, 9);
                end
                6: begin
                    w = $urandom_range(0, 3);
                    h = $urandom_range(0, 3);
                    sel = 3'b111;
                end
                7: begin
                    w = $urandom_range(13, 4095);
                    h = $urandom_range(0, 4095);
                end
                default: begin
                    sel = 3'b000;
                end
            endcase
            if (sel != 3'b000) set_frame(w, h, $urandom_range(0, 1), sel);
            count = $urandom_range(8, 120);
            repeat (count) push_pixel(random_pixel());
            wait_idle();
        end

        repeat (8) @(negedge i_clk);
        $display("run covered %0d pixels over %0d register settings", pixels_sent,
                 settings_written);
        $display("checked %0d chroma blocks and %0d frame ends", chroma_count, frame_count);
        if (fail_count == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
